// ----- src/vdi_pkg.sv -----
`default_nettype none
package vdi_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned KEY_W       = 8 * FIELD_W;
  localparam int unsigned OUT_IDX_W   = 10;

  // power of two, so the pointers wrap on their own
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  typedef struct packed {
    logic               mesh_start;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_z;
    logic [FIELD_W-1:0] tex_u;
    logic [FIELD_W-1:0] tex_v;
    logic [FIELD_W-1:0] norm_x;
    logic [FIELD_W-1:0] norm_y;
    logic [FIELD_W-1:0] norm_z;
  } vdi_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] vertex_index;
    logic                 is_new;
    logic                 table_full;
  } vdi_out_t;

  // request as it travels from the front queue to the search engine
  typedef struct packed {
    logic             mesh_start;
    logic [KEY_W-1:0] key;
  } vdi_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } vdi_state_e;

endpackage
`default_nettype wire

// ----- src/vdi_front.sv -----
`default_nettype none
module vdi_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire vdi_pkg::vdi_in_t  item_i,
  output logic                   full_o,
  output logic                   req_valid_o,
  output vdi_pkg::vdi_req_t      req_o,
  input  wire logic              pop_i
);
  import vdi_pkg::*;

  vdi_req_t          entries_q [QUEUE_DEPTH];
  vdi_req_t          push_req;
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  // pack the vertex into the 256-bit key, first field in the top bits
  assign push_req.mesh_start = item_i.mesh_start;
  assign push_req.key = {item_i.pos_x, item_i.pos_y, item_i.pos_z, item_i.tex_u,
                         item_i.tex_v, item_i.norm_x, item_i.norm_y, item_i.norm_z};

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign req_valid_o = (count_q != '0);
  assign req_o       = entries_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && req_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_req;
    end
  end

endmodule
`default_nettype wire

// ----- src/vdi_search.sv -----
`default_nettype none
module vdi_search (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire vdi_pkg::vdi_req_t req_i,
  output logic                   req_pop_o,
  output logic                   result_valid_o,
  output vdi_pkg::vdi_out_t      result_o
);
  import vdi_pkg::*;

  logic [KEY_W-1:0] mem_q [TABLE_DEPTH];
  logic [KEY_W-1:0] rdata_q;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic             we;

  vdi_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] cmp_q, cmp_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             res_valid_q, res_valid_d;
  vdi_out_t         res_q, res_d;
  logic             last_entry;

  assign last_entry = ((CNT_W'(cmp_q) + 1'b1) == cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmp_d       = cmp_q;
    key_d       = key_q;
    req_pop_o   = 1'b0;
    we          = 1'b0;
    wr_addr     = cnt_q[IDX_W-1:0];
    wr_key      = key_q;
    rd_addr     = cmp_q + 1'b1;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      ST_IDLE: begin
        rd_addr = '0;
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          key_d     = req_i.key;
          if (req_i.mesh_start || cnt_q == '0) begin
            // empty table or mesh start: the vertex always becomes entry 0
            we                 = 1'b1;
            wr_addr            = '0;
            wr_key             = req_i.key;
            cnt_d              = CNT_W'(1);
            res_valid_d        = 1'b1;
            res_d.vertex_index = '0;
            res_d.is_new       = 1'b1;
            res_d.table_full   = 1'b0;
          end else begin
            cmp_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rdata_q holds entry cmp_q
        if (rdata_q == key_q) begin
          state_d            = ST_IDLE;
          res_valid_d        = 1'b1;
          res_d.vertex_index = OUT_IDX_W'(cmp_q);
          res_d.is_new       = 1'b0;
          res_d.table_full   = 1'b0;
        end else if (last_entry) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
            res_d.vertex_index = '0;
            res_d.is_new       = 1'b0;
            res_d.table_full   = 1'b1;
          end else begin
            we                 = 1'b1;
            cnt_d              = cnt_q + 1'b1;
            res_d.vertex_index = OUT_IDX_W'(cnt_q[IDX_W-1:0]);
            res_d.is_new       = 1'b1;
            res_d.table_full   = 1'b0;
          end
        end else begin
          cmp_d = cmp_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q <= cmp_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_key;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
`default_nettype wire

// ----- src/vertex_dedup_indexer_core.sv -----
`default_nettype none
// Vertex deduplicating indexer.
// Request channel: present a vertex on req_i and raise start; the request is
// taken at a rising edge where start is high and busy is low. mesh_start in
// the request empties the table before that vertex is looked up.
// Result channel: result_valid_o is high for exactly one cycle with the
// vertex index, the new flag (append the attributes downstream) and the
// table-full flag. The receiver cannot stall; results come out in request
// order, one per request.
// Requests wait in a two-entry queue; busy is high while it is full.
// A search engine walks the stored vertices one entry per cycle through the
// single read port of the key memory. A request on an empty table or at
// mesh start is decided in the idle state; otherwise k entries are compared,
// k being the number up to the match or up to the end of the table (at most
// the entry count, 1024). The result appears in the cycle after the decision.
// Reset empties the queue and the table at once; no clearing pass is run.
module vertex_dedup_indexer_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire vdi_pkg::vdi_in_t req_i,
  output logic                  result_valid_o,
  output vdi_pkg::vdi_out_t     result_o
);
  import vdi_pkg::*;

  vdi_req_t req;
  logic     req_valid;
  logic     req_pop;

  vdi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start),
    .item_i      (req_i),
    .full_o      (busy),
    .req_valid_o (req_valid),
    .req_o       (req),
    .pop_i       (req_pop)
  );

  vdi_search u_search (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_i          (req),
    .req_pop_o      (req_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire

// ----- tb/vertex_dedup_indexer_core_tb.sv -----
`default_nettype none
module vertex_dedup_indexer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vdi_pkg::*;

  typedef struct {
    vdi_in_t  req;
    bit       typed;
    vdi_out_t want;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  vdi_in_t  req = '0;
  logic     res_valid;
  vdi_out_t res_out;

  // golden copy of the vertex table
  logic [KEY_W-1:0] seen_keys [TABLE_DEPTH];
  int unsigned      seen_count = 0;

  vdi_out_t  pending_results [$];
  stim_row_t stim_rows [$];
  vdi_in_t   mesh_verts [$];
  vdi_in_t   fill_verts [$];
  int        err_count = 0;
  int        items_sent = 0;
  bit        idle_on = 1'b1;

  vertex_dedup_indexer_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (res_valid),
    .result_o       (res_out)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic vdi_in_t vtx(input bit ms, input logic [31:0] px, input logic [31:0] py,
                                  input logic [31:0] pz, input logic [31:0] tu,
                                  input logic [31:0] tv, input logic [31:0] nx,
                                  input logic [31:0] ny, input logic [31:0] nz);
    vdi_in_t v;
    v.mesh_start = ms;
    v.pos_x  = px;
    v.pos_y  = py;
    v.pos_z  = pz;
    v.tex_u  = tu;
    v.tex_v  = tv;
    v.norm_x = nx;
    v.norm_y = ny;
    v.norm_z = nz;
    return v;
  endfunction

  function automatic vdi_in_t flat_vtx(input bit ms, input logic [31:0] w);
    return vtx(ms, w, w, w, w, w, w, w, w);
  endfunction

  function automatic vdi_out_t outcome(input int idx, input bit nw, input bit full);
    vdi_out_t o;
    o.vertex_index = OUT_IDX_W'(idx);
    o.is_new       = nw;
    o.table_full   = full;
    return o;
  endfunction

  function automatic void add_row(input vdi_in_t r, input bit typed, input vdi_out_t want);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // random bits half the time, otherwise a special float pattern
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h3F80_0000;
      4: return 32'h7FC0_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic vdi_in_t rand_vtx(input bit ms);
    return vtx(ms, pick_word(), pick_word(), pick_word(), pick_word(),
               pick_word(), pick_word(), pick_word(), pick_word());
  endfunction

  // look the vertex up in the golden table, storing it when it is new
  function automatic vdi_out_t lookup_vertex(input vdi_in_t r);
    logic [KEY_W-1:0] key;
    vdi_out_t         o;
    int               hit;
    key = {r.pos_x, r.pos_y, r.pos_z, r.tex_u, r.tex_v, r.norm_x, r.norm_y, r.norm_z};
    if (r.mesh_start) seen_count = 0;
    o   = '0;
    hit = -1;
    for (int i = 0; i < seen_count; i++) begin
      if (seen_keys[i] == key) begin
        hit = i;
        break;
      end
    end
    if (hit >= 0) begin
      o.vertex_index = OUT_IDX_W'(hit);
    end else if (seen_count >= TABLE_DEPTH) begin
      o.table_full = 1'b1;
    end else begin
      seen_keys[seen_count] = key;
      o.vertex_index = OUT_IDX_W'(seen_count);
      o.is_new = 1'b1;
      seen_count++;
    end
    return o;
  endfunction

  function automatic void note_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endfunction

  task automatic drive_request(input vdi_in_t r, input bit typed, input vdi_out_t want);
    vdi_out_t pred;
    if (idle_on && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = lookup_vertex(r);
    pending_results.insert(pending_results.size(), typed ? want : pred);
    items_sent++;
  endtask

  task automatic drive_vertex(input vdi_in_t r);
    drive_request(r, 1'b0, '0);
  endtask

  // hold off new requests until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    vdi_out_t want;
    if (rst_ni && res_valid) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: idx=%0d new=%0b full=%0b",
                                res_out.vertex_index, res_out.is_new, res_out.table_full));
      end else begin
        want = pending_results.pop_front();
        if (res_out.vertex_index !== want.vertex_index || res_out.is_new !== want.is_new ||
            res_out.table_full !== want.table_full)
          note_mismatch($sformatf("exp idx=%0d new=%0b full=%0b, got idx=%0d new=%0b full=%0b",
                                  want.vertex_index, want.is_new, want.table_full,
                                  res_out.vertex_index, res_out.is_new, res_out.table_full));
      end
    end
  end

  initial begin
    #(60_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    vdi_in_t v;
    int      mesh_len;
    int      roll;

    // directed rows: typed expectations follow the table contents step by step
    add_row(flat_vtx(1'b0, 32'h0000_0000), 1'b1, outcome(0, 1'b1, 1'b0));
    add_row(flat_vtx(1'b0, 32'hFFFF_FFFF), 1'b1, outcome(1, 1'b1, 1'b0));
    add_row(flat_vtx(1'b0, 32'h0000_0000), 1'b1, outcome(0, 1'b0, 1'b0));
    // negative zero is a different vertex
    add_row(vtx(1'b0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0), 1'b1, outcome(2, 1'b1, 1'b0));
    // NaNs with equal bits match
    add_row(flat_vtx(1'b0, 32'h7FC0_0000), 1'b1, outcome(3, 1'b1, 1'b0));
    add_row(flat_vtx(1'b0, 32'h7FC0_0000), 1'b1, outcome(3, 1'b0, 1'b0));
    add_row(flat_vtx(1'b0, 32'hFFFF_FFFF), 1'b1, outcome(1, 1'b0, 1'b0));
    // mesh start empties the table first
    add_row(flat_vtx(1'b1, 32'hFFFF_FFFF), 1'b1, outcome(0, 1'b1, 1'b0));
    add_row(flat_vtx(1'b0, 32'h0000_0000), 1'b1, outcome(1, 1'b1, 1'b0));
    add_row(vtx(1'b0, 0, 0, 0, 0, 0, 0, 0, 32'h1), 1'b1, outcome(2, 1'b1, 1'b0));
    add_row(vtx(1'b0, 32'h1, 0, 0, 0, 0, 0, 0, 0), 1'b1, outcome(3, 1'b1, 1'b0));
    add_row(flat_vtx(1'b1, 32'h0000_0000), 1'b1, outcome(0, 1'b1, 1'b0));
    add_row(flat_vtx(1'b1, 32'h0000_0000), 1'b1, outcome(0, 1'b1, 1'b0));
    add_row(vtx(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555),
            1'b1, outcome(1, 1'b1, 1'b0));
    add_row(vtx(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA),
            1'b1, outcome(2, 1'b1, 1'b0));
    add_row(vtx(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555),
            1'b1, outcome(1, 1'b0, 1'b0));
    add_row(flat_vtx(1'b0, 32'h7F80_0000), 1'b1, outcome(3, 1'b1, 1'b0));
    add_row(flat_vtx(1'b0, 32'hFF80_0000), 1'b1, outcome(4, 1'b1, 1'b0));
    add_row(flat_vtx(1'b0, 32'h0000_0000), 1'b1, outcome(0, 1'b0, 1'b0));
    add_row(vtx(1'b0, 32'h3F80_0000, 32'hBF80_0000, 0, 32'h3F00_0000, 32'h3F00_0000,
                0, 32'h3F80_0000, 0), 1'b0, '0);
    add_row(vtx(1'b0, 32'h3F80_0000, 32'hBF80_0000, 0, 32'h3F00_0000, 32'h3F00_0000,
                0, 32'h3F80_0000, 0), 1'b0, '0);
    add_row(vtx(1'b0, 32'h3F80_0000, 32'hBF80_0000, 0, 32'h3F00_0000, 32'h3F00_0000,
                0, 32'h3F80_0000, 32'h8000_0000), 1'b0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) drive_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
    drain_results();

    // small meshes with heavy reuse, near copies and stray mesh starts
    while (items_sent < 500) begin
      mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      mesh_verts.delete();
      v = rand_vtx(1'b1);
      drive_vertex(v);
      v.mesh_start = 1'b0;
      mesh_verts.insert(mesh_verts.size(), v);
      for (int j = 1; j < mesh_len; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          v = mesh_verts[$urandom_range(0, mesh_verts.size() - 1)];
        end else if (roll < 58) begin
          v = mesh_verts[$urandom_range(0, mesh_verts.size() - 1)];
          v[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        end else if (roll < 61) begin
          v = rand_vtx(1'b1);
          mesh_verts.delete();
        end else begin
          v = rand_vtx(1'b0);
        end
        drive_vertex(v);
        v.mesh_start = 1'b0;
        mesh_verts.insert(mesh_verts.size(), v);
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();

    // fill the whole table at full rate, then push past its end
    idle_on = 1'b0;
    v = vtx(1'b1, 0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    drive_vertex(v);
    v.mesh_start = 1'b0;
    fill_verts.insert(fill_verts.size(), v);
    while (seen_count < TABLE_DEPTH) begin
      if ($urandom_range(0, 99) < 3) begin
        drive_vertex(fill_verts[$urandom_range(0, fill_verts.size() - 1)]);
      end else begin
        v = vtx(1'b0, 32'(fill_verts.size()), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
        drive_vertex(v);
        fill_verts.insert(fill_verts.size(), v);
      end
    end
    idle_on = 1'b1;
    for (int j = 0; j < 3; j++) drive_vertex(rand_vtx(1'b0));
    drive_vertex(fill_verts[fill_verts.size() - 1]);
    drive_vertex(fill_verts[0]);
    drive_vertex(fill_verts[$urandom_range(0, fill_verts.size() - 1)]);
    drive_vertex(rand_vtx(1'b0));
    drive_vertex(rand_vtx(1'b1));
    drive_vertex(fill_verts[0]);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (pending_results.size() != 0) note_mismatch("results still pending at end of run");
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
